FILE: rtl/core/biu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biu_pkg
// types and constants shared by the bilinear upscaler core
// ----------------------------------------------------------------------------
package biu_pkg;

   // input item: a source pixel load or a destination pixel request
   typedef struct packed {
      logic       action;
      logic [9:0] load_col;
      logic [9:0] load_row;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [11:0] dst_col;
      logic [11:0] dst_row;
   } req_type;

   // result item, blue first
   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rsp_type;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_index_type;

   localparam logic [10:0] SRC_WIDTH_RESET  = 11'd1024;
   localparam logic [10:0] SRC_HEIGHT_RESET = 11'd1024;
   localparam logic [12:0] DST_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] DST_HEIGHT_RESET = 13'd1024;

   localparam int FRAC_W    = 10;
   localparam int NUM_CHAN  = 3;
   localparam int DIV_LANES = 2;
   localparam int NUM_BANKS = 4;

endpackage
`default_nettype wire

FILE: rtl/core/biu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module biu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/biu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biu_div
// pipelined two-lane restoring divider, STEPS quotient bits per stage
// ----------------------------------------------------------------------------
module biu_div #(
   parameter int N_W   = 33,
   parameter int D_W   = 13,
   parameter int STEPS = 4,
   parameter int SB_W  = 69
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   input  wire logic [biu_pkg::DIV_LANES-1:0][N_W-1:0]  in_num,
   input  wire logic [biu_pkg::DIV_LANES-1:0][D_W-1:0]  in_den,
   input  wire logic [SB_W-1:0]                         in_side,
   output logic                                         out_valid,
   output logic      [biu_pkg::DIV_LANES-1:0][N_W-1:0]  out_quo,
   output logic      [SB_W-1:0]                         out_side
);

   localparam int STAGES = (N_W + STEPS - 1) / STEPS;
   localparam int NP     = STAGES * STEPS;
   localparam int L      = biu_pkg::DIV_LANES;

   logic                         valid_ff [STAGES];
   logic [L-1:0][NP-1:0]         work_ff  [STAGES];
   logic [L-1:0][D_W-1:0]        rem_ff   [STAGES];
   logic [L-1:0][D_W-1:0]        den_ff   [STAGES];
   logic [SB_W-1:0]              side_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                  v_src;
      logic [L-1:0][NP-1:0]  w_src;
      logic [L-1:0][D_W-1:0] r_src;
      logic [L-1:0][D_W-1:0] d_src;
      logic [SB_W-1:0]       sb_src;
      logic [L-1:0][NP-1:0]  w_in;
      logic [L-1:0][D_W-1:0] r_in;

      if (s == 0) begin : g_first
         always_comb begin
            v_src  = in_valid;
            sb_src = in_side;
            for (int l = 0; l < L; l++) begin
               w_src[l] = NP'(in_num[l]);
               r_src[l] = '0;
               d_src[l] = in_den[l];
            end
         end
      end else begin : g_next
         always_comb begin
            v_src  = valid_ff[s-1];
            sb_src = side_ff[s-1];
            w_src  = work_ff[s-1];
            r_src  = rem_ff[s-1];
            d_src  = den_ff[s-1];
         end
      end

      // one quotient bit per step, lanes are independent
      always_comb begin
         logic [NP-1:0]  w;
         logic [D_W:0]   t;
         logic [D_W-1:0] r;
         w_in = '0;
         r_in = '0;
         for (int l = 0; l < L; l++) begin
            w = w_src[l];
            r = r_src[l];
            for (int k = 0; k < STEPS; k++) begin
               t = {r, w[NP-1]};
               w = {w[NP-2:0], 1'b0};
               if (t >= {1'b0, d_src[l]}) begin
                  t    = t - {1'b0, d_src[l]};
                  w[0] = 1'b1;
               end
               r = t[D_W-1:0];
            end
            w_in[l] = w;
            r_in[l] = r;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= v_src;
         end
         work_ff[s] <= w_in;
         rem_ff[s]  <= r_in;
         den_ff[s]  <= d_src;
         side_ff[s] <= sb_src;
      end
   end

   always_comb begin
      out_valid = valid_ff[STAGES-1];
      out_side  = side_ff[STAGES-1];
      for (int l = 0; l < L; l++) begin
         out_quo[l] = work_ff[STAGES-1][l][N_W-1:0];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bilinear_image_upscale_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_upscale_top
// bilinear rgb upscaler with a built-in source frame store
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  req       in         start & !busy                   req_data  (biu_pkg::req_type)
//  rsp       out        rsp_valid, one cycle, no stall  rsp_data  (biu_pkg::rsp_type)
//  csr       in/out     psel & penable & pwrite         paddr, pwdata, prdata
//
//  one item is taken every cycle; busy is never raised
//  a request's column step and fixed-point source row are formed by the 9-stage divider
//  loads write the store at the same pipeline point where requests read it,
//  so item order is kept exactly
//  reset is synchronous and clears the valid bits and the size registers;
//  the frame store has no reset and holds garbage until loaded
//  the result side cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module bilinear_image_upscale_top #(
   parameter int MAX_SRC_WIDTH  = 1024,
   parameter int MAX_SRC_HEIGHT = 1024,
   parameter int MAX_DST_SIZE   = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             start,
   output logic                  busy,
   input  wire biu_pkg::req_type req_data,
   // result channel
   output logic                  rsp_valid,
   output biu_pkg::rsp_type      rsp_data,
   // configuration port
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);

   // store split into four banks by row and column parity, so the four taps
   // of one request come out of four different banks in the same cycle
   localparam int CHW     = ($clog2(MAX_SRC_WIDTH) > 1)  ? $clog2(MAX_SRC_WIDTH) - 1  : 1;
   localparam int RHW     = ($clog2(MAX_SRC_HEIGHT) > 1) ? $clog2(MAX_SRC_HEIGHT) - 1 : 1;
   localparam int BANK_AW = CHW + RHW;
   localparam int DIV_NW  = 33;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [10:0] src_width_ff, src_height_ff;
   logic [12:0] dst_width_ff, dst_height_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= biu_pkg::SRC_WIDTH_RESET;
         src_height_ff <= biu_pkg::SRC_HEIGHT_RESET;
         dst_width_ff  <= biu_pkg::DST_WIDTH_RESET;
         dst_height_ff <= biu_pkg::DST_HEIGHT_RESET;
      end else if (csr_write) begin
         case (biu_pkg::reg_index_type'(paddr[3:2]))
            biu_pkg::REG_SRC_WIDTH:  src_width_ff  <= pwdata[10:0];
            biu_pkg::REG_SRC_HEIGHT: src_height_ff <= pwdata[10:0];
            biu_pkg::REG_DST_WIDTH:  dst_width_ff  <= pwdata[12:0];
            biu_pkg::REG_DST_HEIGHT: dst_height_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (biu_pkg::reg_index_type'(paddr[3:2]))
         biu_pkg::REG_SRC_WIDTH:  prdata = {21'd0, src_width_ff};
         biu_pkg::REG_SRC_HEIGHT: prdata = {21'd0, src_height_ff};
         biu_pkg::REG_DST_WIDTH:  prdata = {19'd0, dst_width_ff};
         biu_pkg::REG_DST_HEIGHT: prdata = {19'd0, dst_height_ff};
         default:                 prdata = '0;
      endcase
   end

   // effective sizes: zero acts as one, large values saturate
   logic [10:0] sw_ff, sh_ff, sw_in, sh_in;
   logic [12:0] dw_ff, dh_ff, dw_in, dh_in;

   always_comb begin
      sw_in = (src_width_ff == 11'd0) ? 11'd1 :
              (32'(src_width_ff) > MAX_SRC_WIDTH) ? 11'(MAX_SRC_WIDTH) : src_width_ff;
      sh_in = (src_height_ff == 11'd0) ? 11'd1 :
              (32'(src_height_ff) > MAX_SRC_HEIGHT) ? 11'(MAX_SRC_HEIGHT) : src_height_ff;
      dw_in = (dst_width_ff == 13'd0) ? 13'd1 :
              (32'(dst_width_ff) > MAX_DST_SIZE) ? 13'(MAX_DST_SIZE) : dst_width_ff;
      dh_in = (dst_height_ff == 13'd0) ? 13'd1 :
              (32'(dst_height_ff) > MAX_DST_SIZE) ? 13'(MAX_DST_SIZE) : dst_height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= biu_pkg::SRC_WIDTH_RESET;
         sh_ff <= biu_pkg::SRC_HEIGHT_RESET;
         dw_ff <= biu_pkg::DST_WIDTH_RESET;
         dh_ff <= biu_pkg::DST_HEIGHT_RESET;
      end else begin
         sw_ff <= sw_in;
         sh_ff <= sh_in;
         dw_ff <= dw_in;
         dh_ff <= dh_in;
      end
   end

   // ------------------------------------------------------------------
   // stage a: take the item, form row * src_height
   // the height comes straight from the register so an item taken right
   // after a write already sees the new value
   // ------------------------------------------------------------------
   logic             a_valid_ff;
   biu_pkg::req_type a_item_ff;
   logic [22:0]      a_rs_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      a_item_ff <= req_data;
      a_rs_ff   <= 23'(req_data.dst_row * sh_in);
   end

   // ------------------------------------------------------------------
   // divider: lane 0 gives the column step (src_w << 10) / dst_w,
   // lane 1 gives the fixed-point row (row * src_h << 10) / dst_h
   // ------------------------------------------------------------------
   logic [biu_pkg::DIV_LANES-1:0][DIV_NW-1:0] div_num, div_quo;
   logic [biu_pkg::DIV_LANES-1:0][12:0]       div_den;
   logic                                      d_valid;
   biu_pkg::req_type                          d_item;

   assign div_num[0] = DIV_NW'({sw_ff, 10'd0});
   assign div_num[1] = {a_rs_ff, 10'd0};
   assign div_den[0] = dw_ff;
   assign div_den[1] = dh_ff;

   biu_div #(
      .N_W   (DIV_NW),
      .D_W   (13),
      .STEPS (4),
      .SB_W  ($bits(biu_pkg::req_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (a_item_ff),
      .out_valid (d_valid),
      .out_quo   (div_quo),
      .out_side  (d_item)
   );

   // ------------------------------------------------------------------
   // stage m: column position = step >> 10 + col * step
   // ------------------------------------------------------------------
   logic             m_valid_ff;
   biu_pkg::req_type m_item_ff;
   logic [33:0]      m_pos_ff;
   logic [22:0]      m_sy_ff;
   logic [9:0]       m_v_ff;
   logic [20:0]      d_step;

   assign d_step = div_quo[0][20:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= d_valid;
      end
      m_item_ff <= d_item;
      m_pos_ff  <= 34'(d_item.dst_col * d_step) + 34'(d_step >> biu_pkg::FRAC_W);
      m_sy_ff   <= div_quo[1][32:10];
      m_v_ff    <= div_quo[1][9:0];
   end

   // ------------------------------------------------------------------
   // stage x: taps, weights, edge clamps, load check
   // ------------------------------------------------------------------
   logic             x_valid_ff, x_clamp_ff, x_lower_ff, x_inrange_ff;
   biu_pkg::req_type x_item_ff;
   logic [10:0]      x_x0_ff, x_x1_ff, x_sy_ff;
   logic [9:0]       x_u_ff, x_ur_ff, x_v_ff, x_vr_ff;
   logic [23:0]      m_tap;
   logic [10:0]      sw1, sh1;
   logic             m_clamp, m_last_row;

   assign m_tap      = m_pos_ff[33:10];
   assign sw1        = sw_ff - 11'd1;
   assign sh1        = sh_ff - 11'd1;
   assign m_clamp    = m_tap >= 24'(sw1);
   assign m_last_row = m_sy_ff >= 23'(sh1);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= m_valid_ff;
      end
      x_item_ff    <= m_item_ff;
      x_clamp_ff   <= m_clamp;
      x_x0_ff      <= m_clamp ? sw1 : m_tap[10:0];
      x_x1_ff      <= m_clamp ? sw1 : m_tap[10:0] + 11'd1;
      x_u_ff       <= m_clamp ? 10'd0 : m_pos_ff[9:0];
      x_ur_ff      <= ~m_pos_ff[9:0];
      x_lower_ff   <= ~m_last_row;
      x_sy_ff      <= m_last_row ? sh1 : m_sy_ff[10:0];
      x_v_ff       <= m_v_ff;
      x_vr_ff      <= ~m_v_ff;
      x_inrange_ff <= (32'(m_item_ff.load_col) < MAX_SRC_WIDTH) &&
                      (32'(m_item_ff.load_row) < MAX_SRC_HEIGHT);
   end

   // ------------------------------------------------------------------
   // frame store banks, bank index = {row parity, column parity}
   // ------------------------------------------------------------------
   logic [23:0] bank_rd [biu_pkg::NUM_BANKS];
   logic [23:0] load_px;
   logic        x_load;

   assign load_px = {x_item_ff.in_blue, x_item_ff.in_green, x_item_ff.in_red};
   assign x_load  = x_valid_ff & (x_item_ff.action == biu_pkg::ACT_LOAD) & x_inrange_ff;

   for (genvar b = 0; b < biu_pkg::NUM_BANKS; b++) begin : g_bank
      localparam logic RP = (b >= 2);
      localparam logic CP = ((b % 2) == 1);
      logic [10:0]        rrow, rcol;
      logic [BANK_AW-1:0] raddr, waddr;
      logic               we;

      assign rrow  = (x_sy_ff[0] == RP) ? x_sy_ff : x_sy_ff + 11'd1;
      assign rcol  = (x_x0_ff[0] == CP) ? x_x0_ff : x_x1_ff;
      assign raddr = {RHW'(rrow >> 1), CHW'(rcol >> 1)};
      assign waddr = {RHW'(x_item_ff.load_row >> 1), CHW'(x_item_ff.load_col >> 1)};
      assign we    = x_load & (x_item_ff.load_row[0] == RP) & (x_item_ff.load_col[0] == CP);

      biu_ram #(
         .WIDTH (24),
         .DEPTH (2 ** BANK_AW)
      ) u_ram (
         .clock (clock),
         .we    (we),
         .waddr (waddr),
         .wdata (load_px),
         .raddr (raddr),
         .rdata (bank_rd[b])
      );
   end

   // ------------------------------------------------------------------
   // stage r: read data arrives, weights travel alongside
   // ------------------------------------------------------------------
   logic       r_valid_ff, r_clamp_ff, r_lower_ff, r_sy0_ff, r_x00_ff, r_x10_ff;
   logic [9:0] r_u_ff, r_ur_ff, r_v_ff, r_vr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= x_valid_ff & (x_item_ff.action == biu_pkg::ACT_REQUEST);
      end
      r_clamp_ff <= x_clamp_ff;
      r_lower_ff <= x_lower_ff;
      r_sy0_ff   <= x_sy_ff[0];
      r_x00_ff   <= x_x0_ff[0];
      r_x10_ff   <= x_x1_ff[0];
      r_u_ff     <= x_u_ff;
      r_ur_ff    <= x_ur_ff;
      r_v_ff     <= x_v_ff;
      r_vr_ff    <= x_vr_ff;
   end

   // ------------------------------------------------------------------
   // stage p: horizontal blend of upper and lower rows
   // unused taps are forced to zero so stale store data never leaks in
   // ------------------------------------------------------------------
   logic [23:0] p0, p1, q0, q1;
   logic        p_valid_ff;
   logic [18:0] p_tp_ff [biu_pkg::NUM_CHAN];
   logic [18:0] p_tq_ff [biu_pkg::NUM_CHAN];
   logic [9:0]  p_v_ff, p_vr_ff;

   always_comb begin
      p0 = bank_rd[{r_sy0_ff, r_x00_ff}];
      p1 = r_clamp_ff ? 24'd0 : bank_rd[{r_sy0_ff, r_x10_ff}];
      q0 = r_lower_ff ? bank_rd[{~r_sy0_ff, r_x00_ff}] : 24'd0;
      q1 = (r_lower_ff & ~r_clamp_ff) ? bank_rd[{~r_sy0_ff, r_x10_ff}] : 24'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= r_valid_ff;
      end
      for (int c = 0; c < biu_pkg::NUM_CHAN; c++) begin
         p_tp_ff[c] <= 19'(p0[8*c +: 8] * r_ur_ff) + 19'(p1[8*c +: 8] * r_u_ff);
         p_tq_ff[c] <= 19'(q0[8*c +: 8] * r_ur_ff) + 19'(q1[8*c +: 8] * r_u_ff);
      end
      p_v_ff  <= r_v_ff;
      p_vr_ff <= r_vr_ff;
   end

   // ------------------------------------------------------------------
   // stage q: vertical blend, drop 20 fraction bits, result out
   // ------------------------------------------------------------------
   logic [29:0] acc [biu_pkg::NUM_CHAN];
   logic        rsp_valid_ff;
   biu_pkg::rsp_type rsp_data_ff;

   always_comb begin
      for (int c = 0; c < biu_pkg::NUM_CHAN; c++) begin
         acc[c] = 30'(p_tp_ff[c] * p_vr_ff) + 30'(p_tq_ff[c] * p_v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_valid_ff;
      end
      // store bytes are red, green, blue from the bottom
      rsp_data_ff.out_red   <= acc[0][27:20];
      rsp_data_ff.out_green <= acc[1][27:20];
      rsp_data_ff.out_blue  <= acc[2][27:20];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
